// ===== rtl/core/esc_pkg.sv =====
// Package for the epoch seconds to calendar converter.
// Holds the result structs and the constant tables of year and month starts.
// No dependencies; every file of the block imports it.
package esc_pkg;

	localparam int EPOCH_YEAR = 1970;
	// Years 1970 through 2106 cover every 32-bit seconds count.
	localparam int YEAR_COUNT = 137;
	localparam int YEAR_IDX_W = 8;
	localparam int DAYS_W = 16;
	localparam int DOY_W = 9;
	localparam int SOD_W = 17;
	localparam int MONTHS = 12;
	localparam int FIRST_AFTER_FEB = 2;

	localparam int EPOCH_MOD4 = EPOCH_YEAR % 4;
	localparam int EPOCH_MOD100 = EPOCH_YEAR % 100;
	localparam int EPOCH_MOD400 = EPOCH_YEAR % 400;

	// Exact reciprocals. Each product is shifted right by the named amount.
	localparam logic [25:0] DAY_RECIP = 26'd50903317;   // 1/675, shift 35, on t >> 7
	localparam int DAY_SHIFT = 35;
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	localparam logic [15:0] YEAR_RECIP = 16'd45840;     // 1/366, shift 24
	localparam int YEAR_SHIFT = 24;
	localparam logic [13:0] HOUR_RECIP = 14'd9321;      // 1/225, shift 21, on sod >> 4
	localparam int HOUR_SHIFT = 21;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [10:0] MIN_RECIP = 11'd1093;       // 1/15, shift 14, on rem >> 2
	localparam int MIN_SHIFT = 14;
	localparam logic [5:0] SECS_PER_MIN = 6'd60;

	typedef logic [DAYS_W-1:0] ystart_tab_t [0:YEAR_COUNT-1];
	typedef logic [DOY_W-1:0] mstart_tab_t [0:MONTHS-1];

	// First day of each month in a common year, counted from zero.
	localparam mstart_tab_t MONTH_START = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

	// Leap flag of each year, built at elaboration with wrapping counters.
	function automatic logic [YEAR_COUNT-1:0] build_year_leap();
		logic [YEAR_COUNT-1:0] flags;
		int m4;
		int m100;
		int m400;
		flags = '0;
		m4 = EPOCH_MOD4;
		m100 = EPOCH_MOD100;
		m400 = EPOCH_MOD400;
		for (int i = 0; i < YEAR_COUNT; i++) begin
			flags[i] = ((m4 == 0) && (m100 != 0)) || (m400 == 0);
			m4 = (m4 == 3) ? 0 : m4 + 1;
			m100 = (m100 == 99) ? 0 : m100 + 1;
			m400 = (m400 == 399) ? 0 : m400 + 1;
		end
		return flags;
	endfunction

	localparam logic [YEAR_COUNT-1:0] YEAR_LEAP = build_year_leap();

	// Day number since the epoch on which each year begins.
	function automatic ystart_tab_t build_year_start();
		ystart_tab_t tab;
		int acc;
		acc = 0;
		for (int i = 0; i < YEAR_COUNT; i++) begin
			tab[i] = DAYS_W'(acc);
			acc = acc + (YEAR_LEAP[i] ? 366 : 365);
		end
		return tab;
	endfunction

	localparam ystart_tab_t YEAR_START = build_year_start();

endpackage

// ===== rtl/core/epoch_seconds_to_calendar.sv =====
// Epoch seconds to UTC calendar date and time, streaming top level.
// Instantiates esc_split, esc_date and esc_tod; uses esc_pkg.
//
// Each 32-bit count of seconds since 1970-01-01 00:00:00 UTC is converted to the
// Gregorian year (1970..2106), month, day, hour, minute and second, leap seconds
// not counted. The block takes one transfer per cycle unless the output stalls and
// returns the results in the order of their inputs. The depth comes from the
// chain of constant-reciprocal multiplies (days, year estimate, hour, minute),
// each followed by a register before the remainder that uses it. The whole
// pipeline advances together: when a result waits at the output and the sink is
// not ready, s_tready drops until the result is taken.
module epoch_seconds_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // year[11:0] month[15:12] day[20:16] hour[25:21]
	                               // minute[31:26] second[37:32], zero above
);
	import esc_pkg::*;

	localparam int DEPTH = 7;

	logic              en;
	logic [DEPTH-1:0]  vld_q;
	logic [DAYS_W-1:0] days_s3;
	logic [SOD_W-1:0]  sod_s3;
	date_t             date_s7;
	tod_t              tod_s7;

	assign en = !vld_q[DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	esc_split u_split (
		.clk           (clk),
		.en            (en),
		.epoch_seconds (s_tdata),
		.days_s3       (days_s3),
		.sod_s3        (sod_s3)
	);

	esc_date u_date (
		.clk     (clk),
		.en      (en),
		.days_s3 (days_s3),
		.date_s7 (date_s7)
	);

	esc_tod u_tod (
		.clk    (clk),
		.en     (en),
		.sod_s3 (sod_s3),
		.tod_s7 (tod_s7)
	);

	assign m_tdata = {2'b00, tod_s7.second, tod_s7.minute, tod_s7.hour,
		date_s7.day, date_s7.month, date_s7.year};

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:12] != 4'd0) && (m_tdata[15:12] <= 4'd12))
		else $error("month out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25:21] < 5'd24) && (m_tdata[31:26] < 6'd60)
			&& (m_tdata[37:32] < 6'd60))
		else $error("time of day out of range");

	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[20:16] != 5'd0) && (m_tdata[11:0] >= 12'd1970)
			&& (m_tdata[11:0] <= 12'd2106))
		else $error("day or year out of range");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while the output is stalled");

endmodule

// ===== rtl/core/esc_split.sv =====
// Splits the seconds count into whole days and the second of the day.
// Holds the input register and two stages; uses esc_pkg.
module esc_split (
	input  logic                      clk,
	input  logic                      en,
	input  logic [31:0]               epoch_seconds,
	output logic [esc_pkg::DAYS_W-1:0] days_s3,
	output logic [esc_pkg::SOD_W-1:0]  sod_s3
);
	import esc_pkg::*;

	logic [31:0]        t_s1;
	logic [31:0]        t_s2;
	logic [DAYS_W-1:0]  days_s2;
	logic [50:0]        qprod;
	logic [32:0]        dprod;
	logic [31:0]        sod_full;

	// The low seven bits of 86400 are zero, so divide t >> 7 by 675.
	assign qprod = t_s1[31:7] * DAY_RECIP;
	assign dprod = days_s2 * SECS_PER_DAY;
	assign sod_full = t_s2 - dprod[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= epoch_seconds;
			t_s2 <= t_s1;
			days_s2 <= qprod[DAY_SHIFT +: DAYS_W];
			days_s3 <= days_s2;
			sod_s3 <= sod_full[SOD_W-1:0];
		end
	end

endmodule

// ===== rtl/core/esc_date.sv =====
// Turns a day count since the epoch into year, month and day of month.
// Four stages: year estimate, year correction, month search, output; uses esc_pkg.
module esc_date (
	input  logic                       clk,
	input  logic                       en,
	input  logic [esc_pkg::DAYS_W-1:0] days_s3,
	output esc_pkg::date_t             date_s7
);
	import esc_pkg::*;

	logic [31:0]           yprod;
	logic [YEAR_IDX_W-1:0] yest_s4;
	logic [DAYS_W-1:0]     days_s4;
	logic [YEAR_IDX_W-1:0] ynext;
	logic                  ahead;
	logic [YEAR_IDX_W-1:0] yidx;
	logic [DAYS_W-1:0]     ybase;
	logic [DAYS_W-1:0]     doy_full;
	logic [YEAR_IDX_W-1:0] yidx_s5;
	logic [DOY_W-1:0]      doy_s5;
	logic                  leap_s5;
	logic [DOY_W-1:0]      lim;
	logic [DOY_W-1:0]      mbase;
	logic [3:0]            midx;
	logic [DOY_W-1:0]      dom;
	date_t                 date_s6;

	// days / 366 never exceeds the true year offset and trails it by at most one.
	assign yprod = days_s3 * YEAR_RECIP;

	assign ynext = yest_s4 + YEAR_IDX_W'(1);
	assign ahead = days_s4 >= YEAR_START[ynext];
	assign yidx = ahead ? ynext : yest_s4;
	assign ybase = ahead ? YEAR_START[ynext] : YEAR_START[yest_s4];
	assign doy_full = days_s4 - ybase;

	// Month boundaries from March on move one day later in a leap year.
	always_comb begin
		midx = '0;
		mbase = '0;
		lim = '0;
		for (int m = 1; m < MONTHS; m++) begin
			lim = MONTH_START[m] + DOY_W'(leap_s5 && (m >= FIRST_AFTER_FEB));
			if (doy_s5 >= lim) begin
				midx = 4'(m);
				mbase = lim;
			end
		end
	end

	assign dom = doy_s5 - mbase + DOY_W'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			yest_s4 <= yprod[YEAR_SHIFT +: YEAR_IDX_W];
			days_s4 <= days_s3;
			yidx_s5 <= yidx;
			doy_s5 <= doy_full[DOY_W-1:0];
			leap_s5 <= YEAR_LEAP[yidx];
			date_s6.year <= 12'(EPOCH_YEAR) + 12'(yidx_s5);
			date_s6.month <= midx + 4'd1;
			date_s6.day <= dom[4:0];
			date_s7 <= date_s6;
		end
	end

endmodule

// ===== rtl/core/esc_tod.sv =====
// Turns the second of the day into hour, minute and second.
// Four stages alternating reciprocal multiply and remainder; uses esc_pkg.
module esc_tod (
	input  logic                      clk,
	input  logic                      en,
	input  logic [esc_pkg::SOD_W-1:0] sod_s3,
	output esc_pkg::tod_t             tod_s7
);
	import esc_pkg::*;

	logic [26:0]       hprod;
	logic [SOD_W-1:0]  sod_s4;
	logic [4:0]        hour_s4;
	logic [16:0]       hsecs;
	logic [16:0]       rem_full;
	logic [11:0]       rem_s5;
	logic [4:0]        hour_s5;
	logic [20:0]       mprod;
	logic [11:0]       rem_s6;
	logic [4:0]        hour_s6;
	logic [5:0]        minute_s6;
	logic [11:0]       msecs;
	logic [11:0]       sec_full;

	// 3600 = 16 * 225 and 60 = 4 * 15; the reciprocals are exact over these ranges.
	assign hprod = sod_s3[SOD_W-1:4] * HOUR_RECIP;
	assign hsecs = hour_s4 * SECS_PER_HOUR;
	assign rem_full = sod_s4 - hsecs;
	assign mprod = rem_s5[11:2] * MIN_RECIP;
	assign msecs = minute_s6 * SECS_PER_MIN;
	assign sec_full = rem_s6 - msecs;

	always_ff @(posedge clk) begin
		if (en) begin
			sod_s4 <= sod_s3;
			hour_s4 <= hprod[HOUR_SHIFT +: 5];
			rem_s5 <= rem_full[11:0];
			hour_s5 <= hour_s4;
			rem_s6 <= rem_s5;
			hour_s6 <= hour_s5;
			minute_s6 <= mprod[MIN_SHIFT +: 6];
			tod_s7.hour <= hour_s6;
			tod_s7.minute <= minute_s6;
			tod_s7.second <= sec_full[5:0];
		end
	end

endmodule

// ===== tb/epoch_seconds_to_calendar_test.sv =====
// Self-checking testbench for epoch_seconds_to_calendar.
// Drives seconds counts over the stream input and compares each returned date and time
// against a local calendar computation. Needs only the RTL of the block.
module epoch_seconds_to_calendar_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_ITEMS = 680;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX = 10;
	localparam longint unsigned SECS_MAX = 64'hFFFF_FFFF;
	localparam longint SECS_PER_DAY = 86400;

	// Field order follows m_tdata from the top bit down.
	typedef struct packed {
		logic [1:0]  pad;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
	} calendar_t;

	typedef enum logic [1:0] {
		SINK_ALWAYS,
		SINK_COIN,
		SINK_LONG_STALLS,
		SINK_ONE_IN_FOUR
	} sink_mode_e;

	typedef enum int {
		STIM_UNIFORM,
		STIM_MONTH_EDGE,
		STIM_DAY_EDGE,
		STIM_TOP_END
	} stim_kind_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;     // [31:0] epoch_seconds
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // year, month, day, hour, minute, second from bit 0 up

	logic [31:0] pending_seconds[$];
	calendar_t   expected_dates[$];
	int          errors = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	logic [15:0] sink_cycle = '0;

	epoch_seconds_to_calendar i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in_year(int unsigned y);
		return is_leap_year(y) ? 366 : 365;
	endfunction

	// Month index counts from zero, January first.
	function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
		case (m)
			1: return is_leap_year(y) ? 29 : 28;
			3, 5, 8, 10: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic calendar_t to_calendar(logic [31:0] secs);
		calendar_t   r;
		logic [31:0] t;
		int unsigned days;
		int unsigned yr;
		int unsigned mon;
		r = '0;
		r.second = 6'(secs % 60);
		t = secs / 60;
		r.minute = 6'(t % 60);
		t = t / 60;
		r.hour = 5'(t % 24);
		days = t / 24;
		yr = 1970;
		while (days >= days_in_year(yr)) begin
			days -= days_in_year(yr);
			yr++;
		end
		mon = 0;
		while (mon < 11 && days >= days_in_month(yr, mon)) begin
			days -= days_in_month(yr, mon);
			mon++;
		end
		r.year = 12'(yr);
		r.month = 4'(mon + 1);
		r.day = 5'(days + 1);
		return r;
	endfunction

	// Seconds at midnight on the first day of month m (1..12) of year y.
	function automatic longint month_start_secs(int unsigned y, int unsigned m);
		longint days;
		days = 0;
		for (int unsigned i = 1970; i < y; i++)
			days += days_in_year(i);
		for (int unsigned i = 0; i + 1 < m; i++)
			days += days_in_month(y, i);
		return days * SECS_PER_DAY;
	endfunction

	function automatic logic [31:0] clamp_secs(longint v);
		if (v < 0)
			return '0;
		if (v > longint'(SECS_MAX))
			return '1;
		return 32'(v);
	endfunction

	initial begin
		longint     base;
		longint     span;
		stim_kind_e kind;
		int         pick;
		// Field extremes, unit rollovers and calendar edges, including leap days
		// in 1972 and 2000 and the skipped leap day of 2100.
		pending_seconds.push_back(32'd0);
		pending_seconds.push_back(32'hFFFF_FFFF);
		pending_seconds.push_back(32'hAAAA_AAAA);
		pending_seconds.push_back(32'h5555_5555);
		pending_seconds.push_back(32'd59);
		pending_seconds.push_back(32'd60);
		pending_seconds.push_back(32'd3599);
		pending_seconds.push_back(32'd3600);
		pending_seconds.push_back(32'd86399);
		pending_seconds.push_back(32'd86400);
		pending_seconds.push_back(32'd31535999);
		pending_seconds.push_back(32'd31536000);
		pending_seconds.push_back(32'd68169599);
		pending_seconds.push_back(32'd68169600);
		pending_seconds.push_back(32'd68256000);
		pending_seconds.push_back(32'd94694399);
		pending_seconds.push_back(32'd951782400);
		pending_seconds.push_back(32'd951868800);
		pending_seconds.push_back(32'd4107542399);
		pending_seconds.push_back(32'd4107542400);
		pending_seconds.push_back(32'h7FFF_FFFF);
		pending_seconds.push_back(32'h8000_0000);
		pending_seconds.push_back(32'd4291747199);
		pending_seconds.push_back(32'd4291747200);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 3)
				kind = STIM_UNIFORM;
			else if (pick < 7)
				kind = STIM_MONTH_EDGE;
			else if (pick < 9)
				kind = STIM_DAY_EDGE;
			else
				kind = STIM_TOP_END;
			case (kind)
				STIM_UNIFORM: pending_seconds.push_back($urandom);
				STIM_MONTH_EDGE: begin
					base = month_start_secs($urandom_range(1970, 2106), $urandom_range(1, 12));
					span = $urandom_range(0, 1) ? 3 : 2 * SECS_PER_DAY;
					pending_seconds.push_back(clamp_secs(base - span
						+ longint'($urandom_range(0, 32'(2 * span)))));
				end
				STIM_DAY_EDGE: begin
					base = longint'($urandom_range(0, 49710)) * SECS_PER_DAY;
					pending_seconds.push_back(clamp_secs(base - 90
						+ longint'($urandom_range(0, 180))));
				end
				default: pending_seconds.push_back(32'hFFFF_FFFF - $urandom_range(0, 50000000));
			endcase
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Sample away from the active edge so the queues are settled.
		@(negedge clk);
		while (pending_seconds.size() != 0 || s_tvalid || expected_dates.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_dates.push_back(to_calendar(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					s_tvalid <= 1'b0;
					gap_left--;
				end else if (pending_seconds.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_seconds.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 64);
						gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: the stall pattern changes with bits 8:7 of sink_cycle; results are checked
	// in order against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		calendar_t got;
		calendar_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_cycle <= '0;
			stall_left = 0;
		end else begin
			sink_cycle <= sink_cycle + 1'b1;
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				case (sink_mode_e'(sink_cycle[8:7]))
					SINK_ALWAYS: m_tready <= 1'b1;
					SINK_COIN: m_tready <= 1'($urandom_range(0, 1));
					SINK_LONG_STALLS: begin
						if ($urandom_range(0, 15) == 0) begin
							m_tready <= 1'b0;
							stall_left = $urandom_range(4, 24);
						end else begin
							m_tready <= 1'b1;
						end
					end
					default: m_tready <= (sink_cycle[1:0] != 2'b11);
				endcase
			end

			if (m_tvalid && m_tready) begin
				got = calendar_t'(m_tdata);
				if (expected_dates.size() == 0) begin
					if (errors < REPORT_MAX)
						$display("unexpected result %0d-%0d-%0d %0d:%0d:%0d",
							got.year, got.month, got.day, got.hour, got.minute, got.second);
					errors++;
				end else begin
					want = expected_dates.pop_front();
					if (got.year != want.year || got.month != want.month
							|| got.day != want.day || got.hour != want.hour
							|| got.minute != want.minute || got.second != want.second
							|| got.pad != want.pad) begin
						if (errors < REPORT_MAX)
							$display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d pad %0d, got %0d-%0d-%0d %0d:%0d:%0d pad %0d",
								want.year, want.month, want.day, want.hour, want.minute,
								want.second, want.pad, got.year, got.month, got.day,
								got.hour, got.minute, got.second, got.pad);
						errors++;
					end
				end
			end
		end
	end

	// Ends a run in which no transfer happens on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
